### rtl/label_boundary_overlay_unit_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the label boundary overlay unit
// Clocked checks with synchronous reset disable.
// ----------------------------------------------------------------------------
`ifndef LABEL_BOUNDARY_OVERLAY_UNIT_MACROS_SVH
`define LABEL_BOUNDARY_OVERLAY_UNIT_MACROS_SVH

// same-cycle implication
`define LBO_ASSERT_IMP(name, clk_s, rst_s, ante, cons) \
  name: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error("lbo check failed");

// next-cycle implication
`define LBO_ASSERT_NXT(name, clk_s, rst_s, ante, cons) \
  name: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error("lbo check failed");

`endif

### rtl/lbo_pkg.sv
// ----------------------------------------------------------------------------
// lbo_pkg
// Shared constants and types of the label boundary overlay unit.
// ----------------------------------------------------------------------------
package lbo_pkg;

  localparam int MAX_WIDTH  = 2048;
  localparam int COL_BITS   = $clog2(MAX_WIDTH);
  localparam int CFG_BITS   = 12;
  localparam int LABEL_BITS = 16;
  localparam int PIXEL_BITS = 32;

  // input beat: label then pixel, padded up to whole bytes
  localparam int S_TDATA_BITS = ((LABEL_BITS + PIXEL_BITS + 7) / 8) * 8;

  localparam logic [CFG_BITS-1:0] FRAME_WIDTH_RST  = CFG_BITS'(640);
  localparam logic [CFG_BITS-1:0] FRAME_HEIGHT_RST = CFG_BITS'(480);

  // bytes 0..2 of a marked pixel: B=0, G=0, R=255
  localparam logic [23:0] BOUNDARY_RGB = 24'hFF0000;

  typedef enum logic {
    OP_PIXEL = 1'b0,
    OP_FLUSH = 1'b1
  } op_t;

  typedef enum logic {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } reg_idx_t;

  // per-item decode made at acceptance
  typedef struct packed {
    logic [COL_BITS-1:0] col;
    logic                pixel_item;
    logic                has_result;
    logic                interior;
    logic                frame_end;
  } slot_t;

  // delayed write of the older label line
  typedef struct packed {
    logic                we;
    logic [COL_BITS-1:0] col;
  } older_wr_t;

  // compute stage status
  typedef struct packed {
    logic s1_valid;
    logic s1_adv;
  } stage_stat_t;

endpackage

### rtl/lbo_seq.sv
// ----------------------------------------------------------------------------
// lbo_seq
// Raster position counters, drain state and per-item decode.
// ----------------------------------------------------------------------------
module lbo_seq
  import lbo_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                accept,
  input  logic                op,
  input  logic [CFG_BITS-1:0] frame_width,
  input  logic [CFG_BITS-1:0] frame_height,
  output slot_t               slot
);

  localparam logic [CFG_BITS-1:0] MAX_W = CFG_BITS'(MAX_WIDTH);

  logic [COL_BITS-1:0] column_count, column_count_next;
  logic [CFG_BITS-1:0] row_count, row_count_next;
  logic                draining, draining_next;

  logic [CFG_BITS-1:0] w, h, col_ext, c12, r;
  logic [COL_BITS-1:0] base_col;
  logic [CFG_BITS-1:0] base_row;
  logic                is_flush, last_col, last_row;

  always_comb begin
    is_flush = (op_t'(op) == OP_FLUSH);

    if (frame_width == '0) begin
      w = CFG_BITS'(1);
    end else if (frame_width > MAX_W) begin
      w = MAX_W;
    end else begin
      w = frame_width;
    end
    h = (frame_height == '0) ? CFG_BITS'(1) : frame_height;

    // a pixel item during a drain restarts the frame
    base_col = (!is_flush && draining) ? '0 : column_count;
    base_row = (!is_flush && draining) ? '0 : row_count;

    col_ext  = CFG_BITS'(base_col);
    c12      = (col_ext < w) ? col_ext : w - CFG_BITS'(1);
    r        = (base_row < h) ? base_row : h - CFG_BITS'(1);
    last_col = (c12 == w - CFG_BITS'(1));
    last_row = (r == h - CFG_BITS'(1));

    slot.col        = c12[COL_BITS-1:0];
    slot.pixel_item = !is_flush;
    if (is_flush) begin
      slot.has_result = draining;
      slot.interior   = 1'b0;
      slot.frame_end  = last_col;
    end else begin
      slot.has_result = (r != '0);
      slot.interior   = (r >= CFG_BITS'(2)) && (c12 != '0) && !last_col;
      slot.frame_end  = 1'b0;
    end

    column_count_next = column_count;
    row_count_next    = row_count;
    draining_next     = draining;
    if (is_flush) begin
      if (draining) begin
        if (last_col) begin
          draining_next     = 1'b0;
          column_count_next = '0;
          row_count_next    = '0;
        end else begin
          column_count_next = slot.col + COL_BITS'(1);
        end
      end
    end else begin
      draining_next = 1'b0;
      if (last_col) begin
        column_count_next = '0;
        if (last_row) begin
          draining_next  = 1'b1;
          row_count_next = '0;
        end else begin
          row_count_next = r + CFG_BITS'(1);
        end
      end else begin
        column_count_next = slot.col + COL_BITS'(1);
        row_count_next    = r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
      draining     <= 1'b0;
    end else if (accept) begin
      column_count <= column_count_next;
      row_count    <= row_count_next;
      draining     <= draining_next;
    end
  end

endmodule

### rtl/lbo_line_store.sv
// ----------------------------------------------------------------------------
// lbo_line_store
// Two label lines and one pixel line, registered reads at accept.
// ----------------------------------------------------------------------------
module lbo_line_store
  import lbo_pkg::*;
(
  input  logic                  clk,
  input  logic                  accept,
  input  slot_t                 slot,
  input  logic [LABEL_BITS-1:0] lab,
  input  logic [PIXEL_BITS-1:0] pix,
  input  older_wr_t             older_wr,
  output logic [PIXEL_BITS-1:0] rd_pixel,
  output logic [LABEL_BITS-1:0] rd_mid,
  output logic [LABEL_BITS-1:0] rd_right,
  output logic [LABEL_BITS-1:0] rd_up
);

  logic [LABEL_BITS-1:0] label_prev  [MAX_WIDTH];
  logic [LABEL_BITS-1:0] label_older [MAX_WIDTH];
  logic [PIXEL_BITS-1:0] pixel_line  [MAX_WIDTH];

  logic [COL_BITS-1:0] col_right;

  assign col_right = slot.col + COL_BITS'(1);

  // previous row labels: reads at c and c+1, write of the new label at c
  always_ff @(posedge clk) begin
    if (accept) begin
      rd_mid   <= label_prev[slot.col];
      rd_right <= label_prev[col_right];
      if (slot.pixel_item) begin
        label_prev[slot.col] <= lab;
      end
    end
  end

  // row before that; written one stage later with the label moved out of label_prev
  always_ff @(posedge clk) begin
    if (accept) begin
      rd_up <= label_older[slot.col];
    end
    if (older_wr.we) begin
      label_older[older_wr.col] <= rd_mid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rd_pixel <= pixel_line[slot.col];
      if (slot.pixel_item) begin
        pixel_line[slot.col] <= pix;
      end
    end
  end

endmodule

### rtl/lbo_mark.sv
// ----------------------------------------------------------------------------
// lbo_mark
// Boundary test on the fetched neighbourhood and the result register.
// ----------------------------------------------------------------------------
module lbo_mark
  import lbo_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  accept,
  input  slot_t                 slot,
  input  logic [LABEL_BITS-1:0] lab,
  input  logic [PIXEL_BITS-1:0] rd_pixel,
  input  logic [LABEL_BITS-1:0] rd_mid,
  input  logic [LABEL_BITS-1:0] rd_right,
  input  logic [LABEL_BITS-1:0] rd_up,
  input  logic                  out_ready,
  output stage_stat_t           stat,
  output older_wr_t             older_wr,
  output logic                  out_valid,
  output logic [PIXEL_BITS-1:0] out_pixel,
  output logic                  out_boundary,
  output logic                  out_frame_end
);

  logic                  s1_valid;
  slot_t                 s1;
  logic [LABEL_BITS-1:0] s1_lab;
  logic [LABEL_BITS-1:0] left_label;
  logic                  s1_adv, in_ready, edge_hit;
  logic [PIXEL_BITS-1:0] marked;

  assign s1_adv   = s1_valid && (!s1.has_result || !out_valid || out_ready);
  assign in_ready = !s1_valid || s1_adv;

  assign stat.s1_valid = s1_valid;
  assign stat.s1_adv   = s1_adv;

  assign older_wr.we  = s1_adv && s1.pixel_item;
  assign older_wr.col = s1.col;

  // left neighbour is the previous pixel item's upper-row label at c-1
  assign edge_hit = s1.interior && ((rd_mid != rd_right) || (rd_mid != rd_up) ||
                                    (rd_mid != left_label) || (rd_mid != s1_lab));
  assign marked   = edge_hit ? {rd_pixel[PIXEL_BITS-1:24], BOUNDARY_RGB} : rd_pixel;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1     <= slot;
      s1_lab <= lab;
    end
    if (s1_adv && s1.pixel_item) begin
      left_label <= rd_mid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv && s1.has_result) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1.has_result) begin
      out_pixel     <= marked;
      out_boundary  <= edge_hit;
      out_frame_end <= s1.frame_end;
    end
  end

endmodule

### rtl/label_boundary_overlay_unit.sv
// ----------------------------------------------------------------------------
// label_boundary_overlay_unit
// Four-neighbour segment boundary overlay on a raster pixel stream.
// ----------------------------------------------------------------------------
// Slave stream: one beat per pixel in raster order, tdata = label and pixel,
// tuser = flush flag. After the last pixel of a frame, send one flush beat per
// pixel of the last row to drain it. Master stream: each pixel one row late,
// boundary pixels recolored red, tuser marks them, tlast marks the frame end.
// Row 0 beats and flushes outside a drain give no output beat.
// Config channel: index 0 = frame_width, index 1 = frame_height; always ready,
// write only while the stream is idle.
// Pipeline: an input beat is fetched from the line stores into the compute stage
// at acceptance, then the boundary test result is registered in the output register.
// Throughput: one beat per cycle while m_tready stays high; every line store is
// read at the accepting edge, so no beat waits on a fetch.
// Reset: counters and drain state cleared, registers to 640 x 480; the line
// stores are not cleared; the first rows write each used column before it is read.
// Stall: when the master side holds tready low, the compute stage fills and
// s_tready drops; no beat is lost or repeated.
// ----------------------------------------------------------------------------
`include "label_boundary_overlay_unit_macros.svh"

module label_boundary_overlay_unit
  import lbo_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    s_tvalid,
  output logic                    s_tready,
  input  logic [S_TDATA_BITS-1:0] s_tdata,   // seg_label[15:0], src_pixel[47:16]
  input  logic                    s_tuser,   // op
  output logic                    m_tvalid,
  input  logic                    m_tready,
  output logic [PIXEL_BITS-1:0]   m_tdata,   // out_pixel[31:0]
  output logic                    m_tuser,   // is_boundary
  output logic                    m_tlast,   // frame_end
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic                    cfg_index,
  input  logic [CFG_BITS-1:0]     cfg_data
);

  logic [CFG_BITS-1:0]   frame_width, frame_height;
  logic                  accept;
  slot_t                 slot;
  older_wr_t             older_wr;
  stage_stat_t           stat;
  logic [LABEL_BITS-1:0] lab;
  logic [PIXEL_BITS-1:0] pix;
  logic [PIXEL_BITS-1:0] rd_pixel;
  logic [LABEL_BITS-1:0] rd_mid, rd_right, rd_up;

  assign cfg_ready = 1'b1;
  assign s_tready  = !stat.s1_valid || stat.s1_adv;
  assign accept    = s_tvalid && s_tready;
  assign lab       = s_tdata[LABEL_BITS-1:0];
  assign pix       = s_tdata[LABEL_BITS +: PIXEL_BITS];

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= FRAME_WIDTH_RST;
      frame_height <= FRAME_HEIGHT_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (reg_idx_t'(cfg_index))
        REG_FRAME_WIDTH:  frame_width  <= cfg_data;
        REG_FRAME_HEIGHT: frame_height <= cfg_data;
        default: ;
      endcase
    end
  end

  lbo_seq u_seq (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .op           (s_tuser),
    .frame_width  (frame_width),
    .frame_height (frame_height),
    .slot         (slot)
  );

  lbo_line_store u_store (
    .clk      (clk),
    .accept   (accept),
    .slot     (slot),
    .lab      (lab),
    .pix      (pix),
    .older_wr (older_wr),
    .rd_pixel (rd_pixel),
    .rd_mid   (rd_mid),
    .rd_right (rd_right),
    .rd_up    (rd_up)
  );

  lbo_mark u_mark (
    .clk           (clk),
    .rst           (rst),
    .accept        (accept),
    .slot          (slot),
    .lab           (lab),
    .rd_pixel      (rd_pixel),
    .rd_mid        (rd_mid),
    .rd_right      (rd_right),
    .rd_up         (rd_up),
    .out_ready     (m_tready),
    .stat          (stat),
    .older_wr      (older_wr),
    .out_valid     (m_tvalid),
    .out_pixel     (m_tdata),
    .out_boundary  (m_tuser),
    .out_frame_end (m_tlast)
  );

  // a marked pixel carries the boundary color and is never the frame end
  `LBO_ASSERT_IMP(a_mark_color, clk, rst, m_tvalid && m_tuser,
                  m_tdata[23:0] == BOUNDARY_RGB && !m_tlast)
  // input stalls only behind a full compute stage and a held output
  `LBO_ASSERT_IMP(a_stall_cause, clk, rst, !s_tready,
                  stat.s1_valid && m_tvalid && !m_tready)
  // an accepted beat always lands in the compute stage
  `LBO_ASSERT_NXT(a_stage_load, clk, rst, s_tvalid && s_tready, stat.s1_valid)

endmodule

### test/label_boundary_overlay_unit_tb.sv
// ----------------------------------------------------------------------------
// label_boundary_overlay_unit_tb
// Self-checking bench for the four-neighbour boundary overlay. A short table
// of hand-checked beats covers reset, row 0, clamped counters, an abandoned
// drain and a 3x3 frame. Random frames follow at small, degenerate, wide and
// tall sizes. Output beats are compared with table beats or a line-buffer
// predictor, with bursty input and a stalling output side.
// ----------------------------------------------------------------------------
module label_boundary_overlay_unit_tb
  import lbo_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RAND_ITEMS  = 1100;
  localparam int unsigned SETTLE      = 6;     // output register sits behind the compute stage
  localparam int unsigned END_WAIT    = 4000;
  localparam int unsigned MAX_REPORTS = 60;
  localparam longint unsigned LIMIT_NS = 64'd8_000_000;

  typedef struct packed {
    logic [PIXEL_BITS-1:0] pixel;
    logic                  marked;
    logic                  last;
  } overlay_beat_t;

  typedef enum {ROW_ITEM, ROW_CFG} row_kind_t;
  typedef enum {EXP_MODEL, EXP_NONE, EXP_BEAT} exp_kind_t;
  typedef enum {LBL_BLOCKS, LBL_SPECKLE, LBL_NOISE, LBL_FLAT} label_mode_t;
  typedef enum {RX_OPEN, RX_COIN, RX_THIRD, RX_SLOW} rx_mode_t;

  typedef struct {
    row_kind_t             kind;
    op_t                   op;
    logic [LABEL_BITS-1:0] lab;
    logic [PIXEL_BITS-1:0] pix;
    reg_idx_t              idx;
    logic [CFG_BITS-1:0]   val;
    exp_kind_t             ek;
    overlay_beat_t         want;
  } table_row_t;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    s_tvalid = 1'b0;
  logic                    s_tready;
  logic [S_TDATA_BITS-1:0] s_tdata = '0;
  logic                    s_tuser = 1'b0;
  logic                    m_tvalid;
  logic                    m_tready = 1'b0;
  logic [PIXEL_BITS-1:0]   m_tdata;
  logic                    m_tuser;
  logic                    m_tlast;
  logic                    cfg_valid = 1'b0;
  logic                    cfg_ready;
  logic                    cfg_index = 1'b0;
  logic [CFG_BITS-1:0]     cfg_data = '0;

  label_boundary_overlay_unit uut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Predictor state: register copies, counters and the three line stores
  // --------------------------------------------------------------------------
  logic [CFG_BITS-1:0]   frame_w = FRAME_WIDTH_RST;
  logic [CFG_BITS-1:0]   frame_h = FRAME_HEIGHT_RST;
  int unsigned           col_pos = 0;
  int unsigned           row_pos = 0;
  bit                    draining_last_row = 1'b0;
  logic [LABEL_BITS-1:0] lbl_prev_row  [MAX_WIDTH];
  logic [LABEL_BITS-1:0] lbl_older_row [MAX_WIDTH];
  logic [PIXEL_BITS-1:0] pix_prev_row  [MAX_WIDTH];

  overlay_beat_t pending_pixels[$];

  // typed expectation travelling with the beat on the input side
  exp_kind_t     tab_kind = EXP_MODEL;
  overlay_beat_t tab_beat = '0;

  int unsigned errors = 0;
  int unsigned pixel_beats = 0, flush_beats = 0, out_beats = 0;
  int unsigned marked_beats = 0, frame_ends = 0, settings_run = 0;
  int unsigned rand_beats = 0, burst_left = 0;

  table_row_t directed[$];

  // Returns 1 when the beat produces an output beat, which is left in res.
  function automatic bit overlay_predict(input op_t op, input logic [LABEL_BITS-1:0] lab,
                                         input logic [PIXEL_BITS-1:0] pix,
                                         output overlay_beat_t res);
    int unsigned w, h, c, r, e;
    logic [LABEL_BITS-1:0] mid;
    logic [PIXEL_BITS-1:0] p;
    bit mark, has;
    w = (frame_w == 0) ? 1 : ((frame_w > MAX_WIDTH) ? MAX_WIDTH : int'(frame_w));
    h = (frame_h == 0) ? 1 : int'(frame_h);
    res = '0;
    if (op == OP_FLUSH) begin
      if (!draining_last_row) return 1'b0;
      c = (col_pos < w) ? col_pos : w - 1;
      res.pixel = pix_prev_row[c];
      res.last  = (c + 1 >= w);
      if (c + 1 >= w) begin
        draining_last_row = 1'b0;
        col_pos = 0;
        row_pos = 0;
      end else begin
        col_pos = c + 1;
      end
      return 1'b1;
    end
    // a pixel during a drain starts a new frame
    if (draining_last_row) begin
      draining_last_row = 1'b0;
      col_pos = 0;
      row_pos = 0;
    end
    c = (col_pos < w) ? col_pos : w - 1;
    r = (row_pos < h) ? row_pos : h - 1;
    has = 1'b0;
    if (r >= 1) begin
      e = r - 1;
      p = pix_prev_row[c];
      mark = 1'b0;
      if (e >= 1 && e + 1 < h && c >= 1 && c + 1 < w) begin
        mid = lbl_prev_row[c];
        // older[c-1] was refreshed earlier in this row: left neighbour
        mark = (mid != lbl_prev_row[c+1]) || (mid != lbl_older_row[c]) ||
               (mid != lbl_older_row[c-1]) || (mid != lab);
      end
      res.pixel  = mark ? {p[31:24], BOUNDARY_RGB} : p;
      res.marked = mark;
      has = 1'b1;
    end
    lbl_older_row[c] = lbl_prev_row[c];
    lbl_prev_row[c]  = lab;
    pix_prev_row[c]  = pix;
    if (c + 1 >= w) begin
      col_pos = 0;
      if (r + 1 >= h) begin
        draining_last_row = 1'b1;
        row_pos = 0;
      end else begin
        row_pos = r + 1;
      end
    end else begin
      col_pos = c + 1;
      row_pos = r;
    end
    return has;
  endfunction

  task automatic report_err(input string what, input logic [31:0] want,
                            input logic [31:0] got);
    errors++;
    if (errors <= MAX_REPORTS)
      $display("%0t ns: %s expected %h actual %h", $time, what, want, got);
  endtask

  // --------------------------------------------------------------------------
  // Monitor: compare output beats, then log config writes and input beats
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    overlay_beat_t want, pred;
    bit has;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        out_beats++;
        if (m_tuser) marked_beats++;
        if (m_tlast) frame_ends++;
        if (pending_pixels.size() == 0) begin
          report_err("output beat with none pending, out_pixel", 'x, m_tdata);
        end else begin
          want = pending_pixels.pop_front();
          if (m_tdata !== want.pixel) report_err("out_pixel", want.pixel, m_tdata);
          if (m_tuser !== want.marked) report_err("is_boundary", want.marked, m_tuser);
          if (m_tlast !== want.last) report_err("frame_end", want.last, m_tlast);
        end
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_FRAME_WIDTH) frame_w = cfg_data;
        else frame_h = cfg_data;
      end
      if (s_tvalid && s_tready) begin
        if (op_t'(s_tuser) == OP_FLUSH) flush_beats++;
        else pixel_beats++;
        has = overlay_predict(op_t'(s_tuser), s_tdata[LABEL_BITS-1:0],
                              s_tdata[LABEL_BITS +: PIXEL_BITS], pred);
        if (tab_kind == EXP_BEAT) pending_pixels.push_back(tab_beat);
        else if (tab_kind == EXP_MODEL && has) pending_pixels.push_back(pred);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Output side: stall pattern switches to a random mode for a random span
  // --------------------------------------------------------------------------
  rx_mode_t    rx_mode = RX_OPEN;
  int unsigned rx_span = 0, rx_tick = 0;

  always @(negedge clk) begin
    if (rx_span == 0) begin
      rx_mode = rx_mode_t'($urandom_range(0, 3));
      rx_span = $urandom_range(20, 200);
    end
    rx_span--;
    rx_tick++;
    case (rx_mode)
      RX_OPEN:  m_tready <= 1'b1;
      RX_COIN:  m_tready <= 1'($urandom_range(0, 1));
      RX_THIRD: m_tready <= (rx_tick % 3 == 0);
      default:  m_tready <= (rx_tick % 12 == 0);
    endcase
  end

  // --------------------------------------------------------------------------
  // Input side
  // --------------------------------------------------------------------------
  // called at a falling edge, returns at the falling edge after the beat is taken
  task automatic send_item(input op_t op, input logic [LABEL_BITS-1:0] lab,
                           input logic [PIXEL_BITS-1:0] pix, input exp_kind_t ek,
                           input overlay_beat_t want);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        s_tvalid = 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    s_tvalid = 1'b1;
    s_tuser  = op;
    s_tdata  = S_TDATA_BITS'({pix, lab});
    tab_kind = ek;
    tab_beat = want;
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
  endtask

  task automatic cfg_write(input reg_idx_t idx, input logic [CFG_BITS-1:0] val);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // hold the input until every pending beat is out and the pipe has emptied
  task automatic wait_idle();
    s_tvalid = 1'b0;
    while (pending_pixels.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic dir_item(input op_t op, input logic [LABEL_BITS-1:0] lab,
                          input logic [PIXEL_BITS-1:0] pix, input exp_kind_t ek,
                          input logic [31:0] xp = '0, input logic xb = 1'b0,
                          input logic xl = 1'b0);
    directed.push_back('{ROW_ITEM, op, lab, pix, REG_FRAME_WIDTH, '0, ek, '{xp, xb, xl}});
  endtask

  task automatic dir_cfg(input reg_idx_t idx, input logic [CFG_BITS-1:0] val);
    directed.push_back('{ROW_CFG, OP_PIXEL, '0, '0, idx, val, EXP_NONE, '0});
  endtask

  task automatic run_frame(input int unsigned ew, input int unsigned eh, input bit full,
                           input bit big);
    label_mode_t mode;
    logic [LABEL_BITS-1:0] base, lab;
    int unsigned bw, bh, r, c, n;
    mode = label_mode_t'($urandom_range(0, 3));
    base = LABEL_BITS'($urandom);
    bw = $urandom_range(1, 3);
    bh = $urandom_range(1, 3);
    for (r = 0; r < eh; r++) begin
      for (c = 0; c < ew; c++) begin
        // stray flush mid-frame, never where it would act as a drain beat
        if (!big && (r != 0 || c != 0) && $urandom_range(0, 39) == 0)
          send_item(OP_FLUSH, LABEL_BITS'($urandom), $urandom, EXP_MODEL, '0);
        case (mode)
          LBL_BLOCKS:  lab = LABEL_BITS'(base + (r / bh) * 64 + c / bw);
          LBL_SPECKLE: lab = base ^ LABEL_BITS'($urandom_range(0, 7) == 0);
          LBL_NOISE:   lab = LABEL_BITS'($urandom);
          default:     lab = base;
        endcase
        send_item(OP_PIXEL, lab, $urandom, EXP_MODEL, '0);
      end
    end
    // a short drain is cut off by the next frame's first pixel
    n = full ? ew : $urandom_range(0, ew - 1);
    repeat (n) send_item(OP_FLUSH, LABEL_BITS'($urandom), $urandom, EXP_MODEL, '0);
    rand_beats += ew * eh + n;
  endtask

  initial begin
    int unsigned ph, w, h, ew, eh, nfr, f, i;
    bit big;

    // still at 640 x 480: idle flush, then row 0 pixels give nothing
    dir_item(OP_FLUSH, 16'hFFFF, 32'hFFFF_FFFF, EXP_NONE);
    dir_item(OP_PIXEL, 16'h0000, 32'h0000_0000, EXP_NONE);
    dir_item(OP_PIXEL, 16'hFFFF, 32'hFFFF_FFFF, EXP_NONE);
    dir_item(OP_PIXEL, 16'h5A5A, 32'h1357_9BDF, EXP_NONE);
    // column counter now past the new width: taken as the last column
    dir_cfg(REG_FRAME_WIDTH, 12'd3);
    dir_item(OP_PIXEL, 16'h5A5A, 32'h2468_ACE0, EXP_NONE);
    for (i = 0; i < 6; i++) dir_item(OP_PIXEL, 16'h0001, 32'hC0DE_0000 + i, EXP_MODEL);
    // row counter past the new height: this row closes the frame
    dir_cfg(REG_FRAME_HEIGHT, 12'd3);
    dir_item(OP_PIXEL, 16'h0001, 32'hA5A5_0001, EXP_MODEL);
    dir_item(OP_PIXEL, 16'h0002, 32'hA5A5_0002, EXP_MODEL);
    dir_item(OP_PIXEL, 16'h0001, 32'hA5A5_0003, EXP_MODEL);
    dir_item(OP_FLUSH, 16'h0000, 32'h0000_0000, EXP_MODEL);
    // 3x3 frame with one odd label in the middle; its first pixel drops the drain
    dir_item(OP_PIXEL, 16'h0000, 32'h0000_0000, EXP_NONE);
    dir_item(OP_PIXEL, 16'h0000, 32'hFFFF_FFFF, EXP_NONE);
    dir_item(OP_PIXEL, 16'h0000, 32'h1234_5678, EXP_NONE);
    dir_item(OP_PIXEL, 16'h0000, 32'h1122_3344, EXP_BEAT, 32'h0000_0000);
    dir_item(OP_PIXEL, 16'hFFFF, 32'h80A0_C0E0, EXP_BEAT, 32'hFFFF_FFFF);
    dir_item(OP_PIXEL, 16'h0000, 32'h5566_7788, EXP_BEAT, 32'h1234_5678);
    dir_item(OP_PIXEL, 16'h0000, 32'h99AA_BBCC, EXP_BEAT, 32'h1122_3344);
    dir_item(OP_PIXEL, 16'h0000, 32'h0F1E_2D3C, EXP_BEAT, 32'h80FF_0000, 1'b1);
    dir_item(OP_PIXEL, 16'h0000, 32'h4B5A_6978, EXP_BEAT, 32'h5566_7788);
    dir_item(OP_FLUSH, 16'h0000, 32'h0000_0000, EXP_BEAT, 32'h99AA_BBCC);
    dir_item(OP_FLUSH, 16'h0000, 32'h0000_0000, EXP_BEAT, 32'h0F1E_2D3C);
    dir_item(OP_FLUSH, 16'h0000, 32'h0000_0000, EXP_BEAT, 32'h4B5A_6978, 1'b0, 1'b1);
    dir_item(OP_FLUSH, 16'hFFFF, 32'hFFFF_FFFF, EXP_NONE);

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (directed[k]) begin
      if (directed[k].kind == ROW_CFG) begin
        wait_idle();
        cfg_write(directed[k].idx, directed[k].val);
      end else begin
        send_item(directed[k].op, directed[k].lab, directed[k].pix, directed[k].ek,
                  directed[k].want);
      end
    end

    // random frames; the wide, tall and degenerate sizes come early, once each
    ph = 0;
    while (rand_beats < RAND_ITEMS) begin
      big = 1'b0;
      case (ph)
        1:       begin w = 64;        h = 3;    big = 1'b1; end
        2:       begin w = 0;         h = 5;    end
        3:       begin w = 7;         h = 0;    end
        4:       begin w = 1;         h = 1;    end
        5:       begin w = 3;         h = 64;   big = 1'b1; end
        6:       begin w = 2;         h = 9;    end
        7:       begin w = 9;         h = 2;    end
        default: begin w = $urandom_range(3, 12); h = $urandom_range(3, 7); end
      endcase
      wait_idle();
      cfg_write(REG_FRAME_WIDTH, CFG_BITS'(w));
      cfg_write(REG_FRAME_HEIGHT, CFG_BITS'(h));
      settings_run++;
      ew = (w == 0) ? 1 : ((w > MAX_WIDTH) ? MAX_WIDTH : w);
      eh = (h == 0) ? 1 : h;
      nfr = big ? 1 : $urandom_range(1, 4);
      for (f = 0; f < nfr; f++)
        run_frame(ew, eh, (f + 1 == nfr) || ($urandom_range(0, 5) != 0), big);
      ph++;
    end

    s_tvalid = 1'b0;
    for (i = 0; i < END_WAIT && pending_pixels.size() != 0; i++) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
    if (pending_pixels.size() != 0) begin
      errors++;
      $display("%0t ns: %0d expected output beats never arrived", $time,
               pending_pixels.size());
    end

    $display("run: %0d pixel beats, %0d flush beats, table plus %0d random frame sizes",
             pixel_beats, flush_beats, settings_run);
    $display("out: %0d beats, %0d marked as boundary, %0d frame ends, %0d errors",
             out_beats, marked_beats, frame_ends, errors);
    if (errors == 0) begin
      $display("label_boundary_overlay_unit_tb passed");
    end else begin
      $display("label_boundary_overlay_unit_tb failed");
    end
    $finish;
  end

  initial begin
    #(LIMIT_NS);
    $display("%0t ns: timeout, %0d output beats still pending", $time, pending_pixels.size());
    $display("label_boundary_overlay_unit_tb failed");
    $finish;
  end

endmodule
